FILE: hdl/kest_pkg.sv
// ============================================================================
// kest_pkg: shared types and constants for the keyed expiring slot table
// Holds the opcode and selection codes, the request and slot entry layouts,
// and the command and status bundles between the controller and datapath.
// ============================================================================
package kest_pkg;

   // Default number of slots in the table.
   localparam int ENTRIES_DEF = 32;

   // Width of the reported slot number.
   localparam int SLOT_W = 5;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // How an allocation picked its slot.
   typedef enum logic [1:0] {
      HOW_KEY      = 2'd0,
      HOW_EXPIRED  = 2'd1,
      HOW_FALLBACK = 2'd2,
      HOW_NONE     = 2'd3
   } how_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC_WR,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // One request as captured from the input channel.
   typedef struct packed {
      logic [1:0]         opcode;
      logic [15:0]        light_key;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [15:0]        start_radius;
      logic [15:0]        lifetime;
      logic [15:0]        decay_rate;
      logic [31:0]        now;
      logic [15:0]        frame_time;
   } req_type;

   // One slot as kept in the slot memory.
   typedef struct packed {
      logic [15:0]        key;
      logic [31:0]        expiry;
      logic [15:0]        radius;
      logic [15:0]        decay;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan_run;
      logic alloc_write;
      logic clear_all;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       scan_done;
      logic       rsp_free;
      logic [1:0] opcode;
   } dp_status_type;

endpackage

FILE: hdl/kest_if.sv
// ============================================================================
// kest_if: request and response channels of the keyed expiring slot table
// Each channel carries valid, ready and its payload; a transfer happens on a
// rising clock edge with valid and ready both high.
// ============================================================================
interface kest_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [15:0]        light_key;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic [15:0]        start_radius;
   logic [15:0]        lifetime;
   logic [15:0]        decay_rate;
   logic [31:0]        now;
   logic [15:0]        frame_time;

   modport source (
      output valid, opcode, light_key, pos_x, pos_y, pos_z, start_radius,
             lifetime, decay_rate, now, frame_time,
      input  ready
   );
   modport sink (
      input  valid, opcode, light_key, pos_x, pos_y, pos_z, start_radius,
             lifetime, decay_rate, now, frame_time,
      output ready
   );
endinterface

interface kest_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] slot_index;
   logic [1:0] how_chosen;

   modport source (
      output valid, slot_index, how_chosen,
      input  ready
   );
   modport sink (
      input  valid, slot_index, how_chosen,
      output ready
   );
endinterface

FILE: hdl/kest_ram.sv
// ============================================================================
// kest_ram: simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module kest_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hdl/kest_ctrl.sv
// ============================================================================
// kest_ctrl: sequencing controller for the keyed expiring slot table
// Accepts one request at a time, runs the slot scan, the allocation write or
// the table clear, and hands the result to the response register.
// ============================================================================
module kest_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_opcode,
   output logic                    req_ready,
   output kest_pkg::dp_cmd_type    cmd,
   input  kest_pkg::dp_status_type status
);
   import kest_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (opcode_type'(req_opcode))
                  OP_ALLOC: state_in = ST_SCAN;
                  OP_TICK:  state_in = ST_SCAN;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_NONE:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = (status.opcode == OP_ALLOC) ? ST_ALLOC_WR : ST_DONE;
            end
         end
         ST_ALLOC_WR: state_in = ST_DONE;
         ST_CLEAR:    state_in = ST_DONE;
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cmd.capture     = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_run    = (state_ff == ST_SCAN);
      cmd.alloc_write = (state_ff == ST_ALLOC_WR);
      cmd.clear_all   = (state_ff == ST_CLEAR);
      cmd.load_rsp    = (state_ff == ST_DONE) && status.rsp_free;
   end

   // The allocation write always follows a finished scan.
   a_alloc_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_WR) |-> ($past(state_ff) == ST_SCAN))
      else $error("allocation write without a preceding scan");

   // A scan keeps going until the datapath reports it finished.
   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !status.scan_done) |=> (state_ff == ST_SCAN))
      else $error("scan left before it finished");

   // A clear is followed in the next cycle by the result stage.
   a_clear_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> (state_ff == ST_DONE))
      else $error("clear did not move on to the result stage");

endmodule

FILE: hdl/kest_datapath.sv
// ============================================================================
// kest_datapath: slot storage and scan pipeline
// Holds the slot memory and its valid bits, walks the slots through a read
// pipeline for allocation search and frame decay, and keeps the response
// register.
// ============================================================================
module kest_datapath #(
   parameter int ENTRIES = kest_pkg::ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  kest_pkg::req_type              req_data,
   input  kest_pkg::dp_cmd_type           cmd,
   output kest_pkg::dp_status_type        status,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [kest_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [1:0]                     rsp_how_chosen
);
   import kest_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int ENT_W = $bits(entry_type);

   // Captured request.
   req_type            req_ff;

   // Valid bits: a slot never written since reset or clear reads as zero.
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;

   // Read issue counter and pipeline stages.
   logic [CNT_W-1:0]   rd_cnt_ff;
   logic [CNT_W-1:0]   rd_cnt_in;
   logic               issue;
   logic               s1_vld_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   entry_type          s1_entry;
   logic [31:0]        s1_prod;
   logic               s2_vld_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   entry_type          s2_entry_ff;
   logic [15:0]        s2_loss_ff;
   logic               s2_expired;
   logic               s2_key_hit;
   logic [15:0]        tick_radius;
   logic               tick_wr;

   // First-match tracking for allocation.
   logic               key_found_ff;
   logic [IDX_W-1:0]   key_idx_ff;
   logic               exp_found_ff;
   logic [IDX_W-1:0]   exp_idx_ff;
   logic [IDX_W-1:0]   pick_idx;
   how_type            pick_how;
   entry_type          alloc_entry;
   entry_type          tick_entry;

   // Memory ports.
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   logic [ENT_W-1:0]   ram_rd_data;

   // Response register.
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_idx_ff;
   how_type            rsp_how_ff;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // Read issue counter walks the slots once per scan.
   assign issue = cmd.scan_run && (rd_cnt_ff != CNT_W'(ENTRIES));

   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      if (cmd.capture) begin
         rd_cnt_in = '0;
      end else if (issue) begin
         rd_cnt_in = rd_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         rd_cnt_ff <= rd_cnt_in;
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Stage one: memory data arrives; mask unwritten slots and form the loss.
   assign s1_entry = valid_ff[s1_idx_ff] ? entry_type'(ram_rd_data) : '0;
   assign s1_prod  = {16'd0, req_ff.frame_time} * {16'd0, s1_entry.decay};

   always_ff @(posedge clock) begin
      s1_idx_ff   <= rd_cnt_ff[IDX_W-1:0];
      s2_idx_ff   <= s1_idx_ff;
      s2_entry_ff <= s1_entry;
      s2_loss_ff  <= s1_prod[31:16];
   end

   // Stage two: compare against the request and compute the decayed radius.
   assign s2_expired = (s2_entry_ff.expiry < req_ff.now);
   assign s2_key_hit = (req_ff.light_key != 16'd0) &&
                       (s2_entry_ff.key == req_ff.light_key);

   always_comb begin
      if (s2_expired || (s2_loss_ff >= s2_entry_ff.radius)) begin
         tick_radius = '0;
      end else begin
         tick_radius = s2_entry_ff.radius - s2_loss_ff;
      end
   end

   assign tick_wr = s2_vld_ff && (req_ff.opcode == OP_TICK) &&
                    (s2_entry_ff.radius != 16'd0);

   always_comb begin
      tick_entry        = s2_entry_ff;
      tick_entry.radius = tick_radius;
   end

   // Remember the first key match and the first expired slot.
   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         key_found_ff <= 1'b0;
         exp_found_ff <= 1'b0;
      end else if (s2_vld_ff) begin
         if (s2_key_hit && !key_found_ff) begin
            key_found_ff <= 1'b1;
         end
         if (s2_expired && !exp_found_ff) begin
            exp_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff && s2_key_hit && !key_found_ff) begin
         key_idx_ff <= s2_idx_ff;
      end
      if (s2_vld_ff && s2_expired && !exp_found_ff) begin
         exp_idx_ff <= s2_idx_ff;
      end
   end

   // Allocation choice: key match, then first expired, then slot zero.
   always_comb begin
      priority if (key_found_ff) begin
         pick_idx = key_idx_ff;
         pick_how = HOW_KEY;
      end else if (exp_found_ff) begin
         pick_idx = exp_idx_ff;
         pick_how = HOW_EXPIRED;
      end else begin
         pick_idx = '0;
         pick_how = HOW_FALLBACK;
      end
   end

   always_comb begin
      alloc_entry.key    = req_ff.light_key;
      alloc_entry.expiry = req_ff.now + {16'd0, req_ff.lifetime};
      alloc_entry.radius = req_ff.start_radius;
      alloc_entry.decay  = req_ff.decay_rate;
      alloc_entry.pos_x  = req_ff.pos_x;
      alloc_entry.pos_y  = req_ff.pos_y;
      alloc_entry.pos_z  = req_ff.pos_z;
   end

   // Memory write port: allocation or decay write-back.
   always_comb begin
      wr_en    = tick_wr || cmd.alloc_write;
      wr_addr  = cmd.alloc_write ? pick_idx : s2_idx_ff;
      wr_entry = cmd.alloc_write ? alloc_entry : tick_entry;
   end

   kest_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Valid bits: cleared all at once, set on every write.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Response register: loads when empty or being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (req_ff.opcode == OP_ALLOC) begin
            rsp_idx_ff <= SLOT_W'({{SLOT_W{1'b0}}, pick_idx});
            rsp_how_ff <= pick_how;
         end else begin
            rsp_idx_ff <= '0;
            rsp_how_ff <= HOW_NONE;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_idx_ff;
   assign rsp_how_chosen = rsp_how_ff;

   // Status back to the controller.
   always_comb begin
      status.scan_done = (rd_cnt_ff == CNT_W'(ENTRIES)) && !s1_vld_ff && !s2_vld_ff;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
      status.opcode    = req_ff.opcode;
   end

   // A decay write-back never lands on the slot being read in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && issue) |-> (wr_addr != rd_cnt_ff[IDX_W-1:0]))
      else $error("slot memory written and read at the same address");

   // The allocation write and a decay write-back never compete for the port.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(tick_wr && cmd.alloc_write))
      else $error("two writers on the slot memory");

   // A key match is only reported for a nonzero key.
   a_key_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_write && key_found_ff) |-> (req_ff.light_key != 16'd0))
      else $error("key match reported for the null key");

endmodule

FILE: hdl/keyed_expiring_slot_table.sv
// ============================================================================
// keyed_expiring_slot_table: keyed light slot allocator with expiry
// A table of light slots with key, position, radius, decay and expiry. Allocate
// reuses a slot by key, else the first expired slot, else slot zero; tick
// decays every live radius; clear empties the table.
//
//   Channel    Direction  Handshake       Payload
//   req_chan   in         valid / ready   opcode, key, position, radius, etc.
//   rsp_chan   out        valid / ready   slot_index, how_chosen
//
// Allocate and tick walk every slot through the single read port of the slot
// memory, one slot a cycle; clear and the unused opcode skip the walk.
// Reset clears all slots at once through per-slot valid bits; no clearing pass.
// A stalled response holds in its output register; the next request is taken
// meanwhile, and only its own result waits for that register to drain.
// ============================================================================
module keyed_expiring_slot_table #(
   parameter int ENTRIES = kest_pkg::ENTRIES_DEF
) (
   input logic        clock,
   input logic        reset,
   kest_req_if.sink   req_chan,
   kest_rsp_if.source rsp_chan
);
   import kest_pkg::*;

   req_type       req_data;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Gather the request payload.
   always_comb begin
      req_data.opcode       = req_chan.opcode;
      req_data.light_key    = req_chan.light_key;
      req_data.pos_x        = req_chan.pos_x;
      req_data.pos_y        = req_chan.pos_y;
      req_data.pos_z        = req_chan.pos_z;
      req_data.start_radius = req_chan.start_radius;
      req_data.lifetime     = req_chan.lifetime;
      req_data.decay_rate   = req_chan.decay_rate;
      req_data.now          = req_chan.now;
      req_data.frame_time   = req_chan.frame_time;
   end

   kest_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   kest_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_slot_index (rsp_chan.slot_index),
      .rsp_how_chosen (rsp_chan.how_chosen)
   );

endmodule

FILE: tb/sv/tb.sv
// ============================================================================
// tb: self-checking testbench for the keyed expiring slot table
// Drives allocate, tick, clear and unused requests into the block, keeps its
// own copy of the slot table to predict each slot_index and how_chosen, and
// compares every response transfer against the oldest prediction. Both sides
// idle in random bursts, and the response side holds off for long stretches
// so that the block fills up and stalls its request channel.
// ============================================================================
module tb;
   import kest_pkg::*;

   localparam int ENTRIES     = ENTRIES_DEF;
   localparam int RANDOM_REQS = 1250;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   // Predicted response of one request.
   typedef struct {
      logic [4:0] slot_index;
      how_type    how_chosen;
   } slot_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kest_req_if req_chan ();
   kest_rsp_if rsp_chan ();

   keyed_expiring_slot_table #(.ENTRIES(ENTRIES)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Requests waiting to be offered, and predicted responses not yet seen.
   req_type      light_reqs[$];
   slot_rsp_type pending_slot_rsp[$];

   // Shadow copy of the slot table. Position does not affect any response.
   logic [15:0] shadow_key[ENTRIES];
   logic [31:0] shadow_expiry[ENTRIES];
   logic [15:0] shadow_radius[ENTRIES];
   logic [15:0] shadow_decay[ENTRIES];

   int   mismatch_count = 0;
   int   accepted_reqs  = 0;
   int   cycle_count    = 0;
   int   send_gap       = 0;
   int   recv_gap       = 0;
   int   hold_left      = 0;
   int   holds_done     = 0;
   logic req_taken      = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one request to the shadow table and returns its response.
   function automatic slot_rsp_type table_update(input req_type r);
      slot_rsp_type res;
      logic         found;
      int           pick;
      logic [31:0]  loss;
      res.slot_index = '0;
      res.how_chosen = HOW_NONE;
      found          = 1'b0;
      pick           = 0;
      case (r.opcode)
         OP_ALLOC: begin
            // A nonzero key reuses its slot; else the first expired slot.
            if (r.light_key != 16'd0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!found && shadow_key[i] == r.light_key) begin
                     found          = 1'b1;
                     pick           = i;
                     res.how_chosen = HOW_KEY;
                  end
               end
            end
            for (int i = 0; i < ENTRIES; i++) begin
               if (!found && shadow_expiry[i] < r.now) begin
                  found          = 1'b1;
                  pick           = i;
                  res.how_chosen = HOW_EXPIRED;
               end
            end
            if (!found) begin
               pick           = 0;
               res.how_chosen = HOW_FALLBACK;
            end
            res.slot_index      = pick[4:0];
            shadow_key[pick]    = r.light_key;
            shadow_expiry[pick] = r.now + 32'(r.lifetime);
            shadow_radius[pick] = r.start_radius;
            shadow_decay[pick]  = r.decay_rate;
         end
         OP_TICK: begin
            // Expired live slots die; the others shrink, saturating at zero.
            for (int i = 0; i < ENTRIES; i++) begin
               if (shadow_radius[i] != 16'd0) begin
                  loss = (32'(r.frame_time) * 32'(shadow_decay[i])) >> 16;
                  if (shadow_expiry[i] < r.now || loss >= 32'(shadow_radius[i]))
                     shadow_radius[i] = 16'd0;
                  else
                     shadow_radius[i] = shadow_radius[i] - loss[15:0];
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) begin
               shadow_key[i]    = '0;
               shadow_expiry[i] = '0;
               shadow_radius[i] = '0;
               shadow_decay[i]  = '0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_type make_req(input opcode_type op, input logic [15:0] key,
                                        input logic [31:0] now_ms, input logic [15:0] life,
                                        input logic [15:0] rad, input logic [15:0] dec,
                                        input logic [15:0] ft);
      req_type r;
      r.opcode       = op;
      r.light_key    = key;
      r.pos_x        = 16'($urandom);
      r.pos_y        = 16'($urandom);
      r.pos_z        = 16'($urandom);
      r.start_radius = rad;
      r.lifetime     = life;
      r.decay_rate   = dec;
      r.now          = now_ms;
      r.frame_time   = ft;
      return r;
   endfunction

   // Idling stops near the end of the run and in every third stretch.
   function automatic logic calm_stretch();
      return light_reqs.size() < 100 || ((accepted_reqs / 128) % 3) == 2;
   endfunction

   // Stimulus, reset and end of run.
   initial begin : stimulus
      req_type     r;
      logic [31:0] t_ms;
      logic [31:0] base;
      logic [15:0] key;
      int          pick;
      int          seq_kind;

      for (int i = 0; i < ENTRIES; i++) begin
         shadow_key[i]    = '0;
         shadow_expiry[i] = '0;
         shadow_radius[i] = '0;
         shadow_decay[i]  = '0;
      end
      req_chan.valid        = 1'b0;
      req_chan.opcode       = OP_NONE;
      req_chan.light_key    = '0;
      req_chan.pos_x        = '0;
      req_chan.pos_y        = '0;
      req_chan.pos_z        = '0;
      req_chan.start_radius = '0;
      req_chan.lifetime     = '0;
      req_chan.decay_rate   = '0;
      req_chan.now          = '0;
      req_chan.frame_time   = '0;
      rsp_chan.ready        = 1'b0;

      // Directed part: fallback on an empty table, key reuse, expiry choice,
      // expiry wrap, tick saturation and kill, unused opcode and clear.
      light_reqs.push_back(make_req(OP_CLEAR, 16'h0000, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      light_reqs.push_back(make_req(OP_ALLOC, 16'h0000, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      r = make_req(OP_ALLOC, 16'hFFFF, 32'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      r.pos_x = 16'sh7FFF;
      r.pos_y = 16'sh7FFF;
      r.pos_z = 16'sh7FFF;
      light_reqs.push_back(r);
      light_reqs.push_back(make_req(OP_ALLOC, 16'hFFFF, 32'd0, 16'd1000, 16'd16, 16'hFFFF,
                                    16'd0));
      light_reqs.push_back(make_req(OP_ALLOC, 16'h0001, 32'd1, 16'hFFFF, 16'h1234, 16'h0010,
                                    16'd0));
      r = make_req(OP_ALLOC, 16'h0002, 32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'h0001, 16'd0);
      r.pos_x = 16'sh8000;
      r.pos_y = 16'sh8000;
      r.pos_z = 16'sh8000;
      light_reqs.push_back(r);
      light_reqs.push_back(make_req(OP_TICK, 16'h0000, 32'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF));
      light_reqs.push_back(make_req(OP_ALLOC, 16'h0001, 32'd2, 16'd5, 16'h0100, 16'h0000,
                                    16'd0));
      light_reqs.push_back(make_req(OP_TICK, 16'h0000, 32'd3, 16'd0, 16'd0, 16'd0, 16'h0001));
      light_reqs.push_back(make_req(OP_NONE, 16'($urandom), $urandom, 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom)));
      light_reqs.push_back(make_req(OP_TICK, 16'h0000, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0,
                                    16'd0));
      light_reqs.push_back(make_req(OP_ALLOC, 16'h0000, 32'd5, 16'd0, 16'd0, 16'd0, 16'd0));
      light_reqs.push_back(make_req(OP_ALLOC, 16'h0002, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      light_reqs.push_back(make_req(OP_CLEAR, 16'($urandom), $urandom, 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom)));
      light_reqs.push_back(make_req(OP_ALLOC, 16'h0003, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      light_reqs.push_back(make_req(OP_ALLOC, 16'h0003, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      light_reqs.push_back(make_req(OP_ALLOC, 16'h0004, 32'd10, 16'd0, 16'd0, 16'd0, 16'd0));

      // Random part: table fill sequences that end in fallback, and mixed
      // traffic with a mostly advancing clock so that slots expire.
      t_ms = $urandom_range(1, 1000);
      while (light_reqs.size() < RANDOM_REQS + 17) begin
         seq_kind = $urandom_range(0, 3);
         if (seq_kind == 0) begin
            base = t_ms + 1;
            light_reqs.push_back(make_req(OP_CLEAR, 16'($urandom), $urandom, 16'($urandom),
                                          16'($urandom), 16'($urandom), 16'($urandom)));
            for (int k = 0; k < ENTRIES + 4; k++) begin
               key = (k % 7 == 6) ? 16'($urandom_range(1, 40)) : 16'(k + 100);
               light_reqs.push_back(make_req(OP_ALLOC, key, base,
                                             16'($urandom_range(1000, 65535)),
                                             16'($urandom), 16'($urandom), 16'($urandom)));
            end
            light_reqs.push_back(make_req(OP_TICK, 16'($urandom), base, 16'($urandom),
                                          16'($urandom), 16'($urandom), 16'($urandom)));
            t_ms = base;
         end else begin
            for (int k = 0; k < 40; k++) begin
               t_ms = t_ms + $urandom_range(0, 400);
               pick = $urandom_range(0, 9);
               key  = (pick == 0) ? 16'd0 :
                      (pick <= 6) ? 16'($urandom_range(1, 40)) : 16'($urandom);
               r = make_req(OP_ALLOC, key, ($urandom_range(0, 9) == 0) ? $urandom : t_ms,
                            ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                                                          16'($urandom_range(0, 3000)),
                            16'($urandom), 16'($urandom), 16'($urandom));
               pick = $urandom_range(0, 99);
               if (pick >= 92)
                  r.opcode = OP_NONE;
               else if (pick >= 87)
                  r.opcode = OP_CLEAR;
               else if (pick >= 65)
                  r.opcode = OP_TICK;
               light_reqs.push_back(r);
            end
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (light_reqs.size() != 0 || req_chan.valid || pending_slot_rsp.size() != 0)
         @(posedge clock);
      repeat (2 * ENTRIES + 10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Request driver: offers the next queued item once the current one has
   // made its transfer, with random idle bursts between items.
   always @(negedge clock) begin : drive_requests
      req_type r;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (light_reqs.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (!calm_stretch() && $urandom_range(0, 99) < 10) begin
            send_gap = $urandom_range(0, 17);
            req_chan.valid <= 1'b0;
         end else begin
            r = light_reqs.pop_front();
            req_chan.opcode       <= r.opcode;
            req_chan.light_key    <= r.light_key;
            req_chan.pos_x        <= r.pos_x;
            req_chan.pos_y        <= r.pos_y;
            req_chan.pos_z        <= r.pos_z;
            req_chan.start_radius <= r.start_radius;
            req_chan.lifetime     <= r.lifetime;
            req_chan.decay_rate   <= r.decay_rate;
            req_chan.now          <= r.now;
            req_chan.frame_time   <= r.frame_time;
            req_chan.valid        <= 1'b1;
         end
      end
   end

   // Response receiver: random stall bursts, plus two long hold-offs while
   // the sender keeps offering requests.
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (holds_done < 2 && accepted_reqs >= 250 + 500 * holds_done) begin
         holds_done = holds_done + 1;
         hold_left  = HOLD_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap = recv_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!calm_stretch() && $urandom_range(0, 99) < 12) begin
         recv_gap = $urandom_range(0, 17);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Monitor: checks each response transfer, then predicts each request
   // transfer seen on the same edge.
   always @(posedge clock) begin : watch_channels
      req_type      seen;
      slot_rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_slot_rsp.size() == 0) begin
               $error("unexpected response: slot_index %0d how_chosen %0d",
                      rsp_chan.slot_index, rsp_chan.how_chosen);
               mismatch_count++;
            end else begin
               want = pending_slot_rsp.pop_front();
               if (rsp_chan.slot_index !== want.slot_index) begin
                  $error("slot_index: expected %0d, actual %0d",
                         want.slot_index, rsp_chan.slot_index);
                  mismatch_count++;
               end
               if (rsp_chan.how_chosen !== want.how_chosen) begin
                  $error("how_chosen: expected %0d, actual %0d",
                         want.how_chosen, rsp_chan.how_chosen);
                  mismatch_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            req_taken         = 1'b1;
            seen.opcode       = req_chan.opcode;
            seen.light_key    = req_chan.light_key;
            seen.pos_x        = req_chan.pos_x;
            seen.pos_y        = req_chan.pos_y;
            seen.pos_z        = req_chan.pos_z;
            seen.start_radius = req_chan.start_radius;
            seen.lifetime     = req_chan.lifetime;
            seen.decay_rate   = req_chan.decay_rate;
            seen.now          = req_chan.now;
            seen.frame_time   = req_chan.frame_time;
            pending_slot_rsp.push_back(table_update(seen));
            accepted_reqs++;
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
